@@ design/drd_pkg.sv @@
// Package for the detection row decoder: item types, register indexes,
// limits and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drd_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int HEAD_LEN    = 5;
  localparam int PIX_MAX     = 16383;
  localparam int CONF_MAX    = 4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_SCALE_Y     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_LEFT        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_TOP         = 3'd5;

  typedef struct packed {
    logic [23:0] element_value;
    logic        row_last;
  } drd_in_t;

  typedef struct packed {
    logic [6:0]  class_id;
    logic [12:0] confidence;
    logic [13:0] box_left;
    logic [13:0] box_top;
    logic [13:0] box_width;
    logic [13:0] box_height;
  } drd_out_t;

endpackage

`default_nettype wire

@@ design/detection_row_decode_top.sv @@
// Detection row decoder top level: running argmax over a row, then a two-stage
// result path (row snapshot, multiply), round/clamp into an output register.
// Depends on drd_pkg.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  drd_in_t  (element_value, row_last)
//   out      source     out_valid / out_stall drd_out_t (class, confidence, box)
//   cfg      sink       cfg_write            cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low. out_valid rises once the
// row's last item has passed the snapshot, product and output registers;
// rows without a detection give nothing. The snapshot stage and the product
// stage each hold one row result, so in_stall rises only when both are full,
// the product stage's row passes the threshold and out_stall holds a full output
// register. Synchronous reset clears the counter, argmax and all valid bits and
// loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module detection_row_decode_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire drd_pkg::drd_in_t                 in_item,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      drd_pkg::drd_out_t                out_item,
  input  wire logic                             cfg_write,
  input  wire logic [drd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [drd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import drd_pkg::*;

  // configuration
  logic [12:0] class_threshold;
  logic [7:0]  class_count;
  logic [23:0] inv_scale_x;
  logic [23:0] inv_scale_y;
  logic [11:0] pad_left;
  logic [11:0] pad_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_threshold <= 13'd1024;
      class_count     <= 8'd80;
      inv_scale_x     <= 24'd65536;
      inv_scale_y     <= 24'd65536;
      pad_left        <= '0;
      pad_top         <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CLASS_THRESHOLD: class_threshold <= cfg_data[12:0];
        REG_CLASS_COUNT:     class_count     <= cfg_data[7:0];
        REG_INV_SCALE_X:     inv_scale_x     <= cfg_data;
        REG_INV_SCALE_Y:     inv_scale_y     <= cfg_data;
        REG_PAD_LEFT:        pad_left        <= cfg_data[11:0];
        REG_PAD_TOP:         pad_top         <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // row accumulation
  logic [7:0]  element_index;
  logic [23:0] box_fields [4];
  logic [23:0] objectness;
  logic [23:0] best_score;
  logic [6:0]  best_class;

  logic        accept;
  logic [7:0]  n_eff;
  logic [8:0]  row_len;
  logic [7:0]  cnt;
  logic        in_class;
  logic        take_best;
  logic [23:0] best_score_next;
  logic [6:0]  best_class_next;
  logic        row_complete;

  always_comb begin
    n_eff = class_count;
    if (class_count == 8'd0) n_eff = 8'd1;
    if (class_count > 8'(MAX_CLASSES)) n_eff = 8'(MAX_CLASSES);
    row_len   = 9'(HEAD_LEN) + {1'b0, n_eff};
    cnt       = (element_index == 8'hFF) ? 8'hFF : element_index + 8'd1;
    in_class  = (element_index >= 8'(HEAD_LEN)) && ({1'b0, element_index} < row_len);
    take_best = in_class && ((element_index == 8'(HEAD_LEN)) ||
                             (in_item.element_value > best_score));
    best_score_next = take_best ? in_item.element_value : best_score;
    best_class_next = take_best ? 7'(element_index - 8'(HEAD_LEN)) : best_class;
    row_complete    = {1'b0, cnt} >= row_len;
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
      best_score    <= '0;
      best_class    <= '0;
    end else if (accept) begin
      element_index <= in_item.row_last ? 8'd0 : cnt;
      best_score    <= best_score_next;
      best_class    <= best_class_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (element_index < 8'd4) box_fields[element_index[1:0]] <= in_item.element_value;
      if (element_index == 8'd4) objectness <= in_item.element_value;
    end
  end

  // stage 1: row snapshot
  logic        s1_valid;
  logic [23:0] s1_obj;
  logic [23:0] s1_best;
  logic [6:0]  s1_class;
  logic [23:0] s1_box [4];

  // stage 2: products
  logic               s2_valid;
  logic [23:0]        s2_obj;
  logic [6:0]         s2_class;
  logic [47:0]        s2_prod;
  logic signed [50:0] s2_cx;
  logic signed [50:0] s2_cy;
  logic [47:0]        s2_w;
  logic [47:0]        s2_h;

  logic s2_pass;
  logic out_ready;
  logic s2_ready;
  logic s1_ready;

  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid || out_ready || !s2_pass;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= accept && in_item.row_last && row_complete;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_obj   <= objectness;
      s1_best  <= best_score_next;
      s1_class <= best_class_next;
      s1_box   <= box_fields;
    end
  end

  logic signed [25:0] dx;
  logic signed [25:0] dy;

  always_comb begin
    dx = $signed({2'b00, s1_box[0]}) - $signed({2'b00, pad_left, 12'h000});
    dy = $signed({2'b00, s1_box[1]}) - $signed({2'b00, pad_top, 12'h000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_obj   <= s1_obj;
      s2_class <= s1_class;
      s2_prod  <= s1_obj * s1_best;
      s2_cx    <= dx * $signed({1'b0, inv_scale_x});
      s2_cy    <= dy * $signed({1'b0, inv_scale_y});
      s2_w     <= s1_box[2] * inv_scale_x;
      s2_h     <= s1_box[3] * inv_scale_y;
    end
  end

  // corner = centre - size/2 in Q.28, rounded half up, clamped to [0, PIX_MAX]
  function automatic logic [13:0] corner_pixel(input logic signed [50:0] centre,
                                               input logic [47:0] size);
    logic signed [52:0] v;
    logic [52:0]        r;
    v = ($signed(53'(centre)) <<< 1) - $signed({5'b00000, size})
        + $signed(53'd1 << 28);
    r = ($unsigned(v) + (53'd1 << 28)) >> 29;
    if (v <= 53'sd0)              corner_pixel = '0;
    else if (r > 53'(PIX_MAX))    corner_pixel = 14'(PIX_MAX);
    else                          corner_pixel = r[13:0];
  endfunction

  function automatic logic [13:0] size_pixel(input logic [47:0] size);
    logic [48:0] r;
    r = ({1'b0, size} + (49'd1 << 27)) >> 28;
    size_pixel = (r > 49'(PIX_MAX)) ? 14'(PIX_MAX) : r[13:0];
  endfunction

  logic [48:0]  conf_sum;
  logic [36:0]  conf_q;
  drd_out_t     result;

  always_comb begin
    s2_pass  = ({11'b0, class_threshold} <= s2_obj) &&
               ({23'b0, class_threshold, 12'h000} <= s2_prod);
    conf_sum = {1'b0, s2_prod} + 49'd2048;
    conf_q   = conf_sum[48:12];
    result.class_id   = s2_class;
    result.confidence = (conf_q > 37'(CONF_MAX)) ? 13'(CONF_MAX) : conf_q[12:0];
    result.box_left   = corner_pixel(s2_cx, s2_w);
    result.box_top    = corner_pixel(s2_cy, s2_h);
    result.box_width  = size_pixel(s2_w);
    result.box_height = size_pixel(s2_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid && s2_pass;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_item <= result;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid && out_stall))
    else $error("input stalled while the result path has room");

  a_short_row_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.row_last && !row_complete) |=> !s1_valid)
    else $error("incomplete row entered the result path");

  a_index_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_item.row_last) |=> (element_index == 8'd0))
    else $error("element index did not restart after row end");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.confidence <= 13'(CONF_MAX)))
    else $error("confidence above saturation limit");

  a_out_from_s2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid))
    else $error("result appeared without a product stage entry");

endmodule

`default_nettype wire

@@ dv/drd_decode_checker.sv @@
// Scoreboard for the detection row decoder: watches the item, result and register
// ports, predicts each row's detection and compares it field by field.
// Depends on drd_pkg.
`timescale 1ns / 1ps

module drd_decode_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  drd_pkg::drd_in_t                 in_item,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  drd_pkg::drd_out_t                out_item,
  input  logic                             cfg_write,
  input  logic [drd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               mismatch_count,
  output int                               detections_due,
  output int                               detections_checked
);
  import drd_pkg::*;

  localparam longint ONE_Q28 = longint'(1) << 28;

  // register copies
  logic [12:0] thr_cfg;
  logic [7:0]  count_cfg;
  logic [23:0] scale_x_cfg;
  logic [23:0] scale_y_cfg;
  logic [11:0] pad_x_cfg;
  logic [11:0] pad_y_cfg;

  // row state
  int unsigned elem_pos;
  logic [23:0] box_acc [4];
  logic [23:0] objness;
  logic [23:0] top_score;
  logic [6:0]  top_class;

  drd_out_t detection_q [$];
  drd_out_t due;

  // corner = centre - extent/2 in Q.28, rounded and clamped to [0, PIX_MAX]
  function automatic logic [13:0] corner_px(input longint centre, input longint extent);
    longint v;
    longint r;
    v = 2 * centre - extent + ONE_Q28;
    if (v <= 0) return '0;
    r = (v + ONE_Q28) >> 29;
    return (r > PIX_MAX) ? 14'(PIX_MAX) : 14'(r);
  endfunction

  function automatic logic [13:0] size_px(input longint extent);
    longint r;
    r = (extent + (ONE_Q28 >> 1)) >> 28;
    return (r > PIX_MAX) ? 14'(PIX_MAX) : 14'(r);
  endfunction

  // Fold one element into the row state; on the row's last element return
  // whether a detection comes out, and its fields.
  function automatic bit decode_element(input drd_in_t item, output drd_out_t det);
    int unsigned n_cls;
    int unsigned seen;
    longint thr;
    longint obj;
    longint prod;
    longint conf;
    longint bx, by, bw, bh, sx, sy, pl, pt;
    longint cx, cy, w, h;
    det = '0;
    n_cls = (count_cfg == 0) ? 1 : (count_cfg > MAX_CLASSES) ? MAX_CLASSES : count_cfg;
    if (elem_pos < 4) begin
      box_acc[elem_pos] = item.element_value;
    end else if (elem_pos == 4) begin
      objness = item.element_value;
    end else if (elem_pos < HEAD_LEN + n_cls) begin
      // first maximum wins: only a strictly larger score replaces it
      if (elem_pos == HEAD_LEN || item.element_value > top_score) begin
        top_score = item.element_value;
        top_class = 7'(elem_pos - HEAD_LEN);
      end
    end
    seen = (elem_pos < 32'hFFFF) ? elem_pos + 1 : 32'hFFFF;
    if (!item.row_last) begin
      elem_pos = seen;
      return 1'b0;
    end
    elem_pos = 0;
    if (seen < HEAD_LEN + n_cls) return 1'b0;

    thr = thr_cfg;
    obj = objness;
    if (obj < thr) return 1'b0;
    prod = obj * longint'(top_score);
    if (prod < (thr << 12)) return 1'b0;
    conf = (prod + 2048) >> 12;
    if (conf > CONF_MAX) conf = CONF_MAX;

    bx = box_acc[0];
    by = box_acc[1];
    bw = box_acc[2];
    bh = box_acc[3];
    sx = scale_x_cfg;
    sy = scale_y_cfg;
    pl = pad_x_cfg;
    pt = pad_y_cfg;
    cx = (bx - (pl << 12)) * sx;
    cy = (by - (pt << 12)) * sy;
    w  = bw * sx;
    h  = bh * sy;

    det.class_id   = top_class;
    det.confidence = 13'(conf);
    det.box_left   = corner_px(cx, w);
    det.box_top    = corner_px(cy, h);
    det.box_width  = size_px(w);
    det.box_height = size_px(h);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr_cfg            = 13'd1024;
      count_cfg          = 8'd80;
      scale_x_cfg        = 24'd65536;
      scale_y_cfg        = 24'd65536;
      pad_x_cfg          = '0;
      pad_y_cfg          = '0;
      elem_pos           = 0;
      box_acc            = '{default: '0};
      objness            = '0;
      top_score          = '0;
      top_class          = '0;
      mismatch_count     = 0;
      detections_checked = 0;
      detection_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CLASS_THRESHOLD: thr_cfg     = cfg_data[12:0];
          REG_CLASS_COUNT:     count_cfg   = cfg_data[7:0];
          REG_INV_SCALE_X:     scale_x_cfg = cfg_data[23:0];
          REG_INV_SCALE_Y:     scale_y_cfg = cfg_data[23:0];
          REG_PAD_LEFT:        pad_x_cfg   = cfg_data[11:0];
          REG_PAD_TOP:         pad_y_cfg   = cfg_data[11:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (detection_q.size() == 0) begin
          $error("unexpected detection: class_id %0d, confidence %0d",
                 out_item.class_id, out_item.confidence);
          mismatch_count++;
        end else begin
          due = detection_q.pop_front();
          check_field("class_id",   due.class_id,   out_item.class_id);
          check_field("confidence", due.confidence, out_item.confidence);
          check_field("box_left",   due.box_left,   out_item.box_left);
          check_field("box_top",    due.box_top,    out_item.box_top);
          check_field("box_width",  due.box_width,  out_item.box_width);
          check_field("box_height", due.box_height, out_item.box_height);
          detections_checked++;
        end
      end

      if (in_valid && !in_stall && decode_element(in_item, due)) begin
        detection_q.insert(detection_q.size(), due);
      end
    end
    detections_due = detection_q.size();
  end

endmodule

@@ dv/tb_detection_row_decode_top.sv @@
// Testbench top for detection_row_decode_top: clock, reset, row stimulus with
// random gaps and output stalls, register phases and the verdict.
// Depends on drd_pkg, detection_row_decode_top and drd_decode_checker.
`timescale 1ns / 1ps

module tb_detection_row_decode_top;
  import drd_pkg::*;

  localparam int ITEM_TARGET   = 1450;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  drd_in_t                in_item;
  logic                   out_valid;
  logic                   out_stall;
  drd_out_t               out_item;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int detections_due;
  int detections_checked;

  logic [23:0] row_buf [$];
  int          n_eff;
  int          rows_sent;
  int          total_items;
  int          useful_items;
  int          settings_used;
  int          quiet_cycles;
  bit          calm_in;
  bit          calm_out;

  detection_row_decode_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  drd_decode_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item           (out_item),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .detections_due     (detections_due),
    .detections_checked (detections_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one element to the row under construction.
  task automatic add_element(input logic [23:0] value);
    row_buf.insert(row_buf.size(), value);
  endtask

  // Send the row in row_buf, last flag on its final element.
  task automatic send_row();
    int gap;
    for (int i = 0; i < row_buf.size(); i++) begin
      gap = calm_in ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= '{element_value: row_buf[i], row_last: (i == row_buf.size() - 1)};
      do @(posedge clk); while (in_stall);
      total_items++;
      if (i < HEAD_LEN + n_eff) useful_items++;
    end
    rows_sent++;
    if ($urandom_range(0, 15) == 0) calm_in = !calm_in;
  endtask

  // Hold the input idle until every detection is out, then let rows that
  // gave nothing clear the pipeline.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (detections_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_config(input logic [23:0] thr, cnt, sx, sy, pl, pt);
    put_reg(REG_CLASS_THRESHOLD, thr);
    put_reg(REG_CLASS_COUNT, cnt);
    put_reg(REG_INV_SCALE_X, sx);
    put_reg(REG_INV_SCALE_Y, sy);
    put_reg(REG_PAD_LEFT, pl);
    put_reg(REG_PAD_TOP, pt);
    cfg_write <= 1'b0;
    n_eff = (cnt[7:0] == 0) ? 1 : (cnt[7:0] > MAX_CLASSES) ? MAX_CLASSES : cnt[7:0];
    settings_used++;
  endtask

  // output side: stall a random number of cycles before each item
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      hold = calm_out ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAIL detection_row_decode_top");
      $finish;
    end
  end

  initial begin
    logic [23:0] thr, cnt, sx, sy, pl, pt;
    int phase, rows, full, len, pick, long_rows;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: two classes, a small left pad so an edge box goes negative.
    program_config(24'd1024, 24'd2, 24'd65536, 24'd65536, 24'd5, 24'd0);
    // extreme box, tied top scores: class 0 wins, confidence reaches the CONF_MAX limit
    row_buf = '{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd4096, 24'd4096, 24'd4096};
    send_row();
    // all zero: objectness below threshold
    row_buf = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
    send_row();
    // short row
    row_buf = '{24'(10 * 4096), 24'(20 * 4096), 24'(30 * 4096)};
    send_row();
    // second class best, half-pixel width, trailing mask element carries the last flag
    row_buf = '{24'(320 * 4096), 24'(240 * 4096), 24'(64 * 4096 + 2048), 24'(48 * 4096),
                24'd3000, 24'd100, 24'd3500, 24'h800000};
    send_row();

    phase     = 0;
    long_rows = 0;
    while (total_items < ITEM_TARGET) begin
      phase++;
      case (phase)
        1: begin
          thr = 24'd0; cnt = 24'd0; sx = 24'd0; sy = 24'd0; pl = 24'd4095; pt = 24'd4095;
        end
        2: begin
          thr = 24'd4096; cnt = 24'd255; sx = 24'hFFFFFF; sy = 24'hFFFFFF; pl = 24'd0; pt = 24'd0;
        end
        3: begin
          thr = 24'd8191; cnt = 24'd1; sx = 24'd1; sy = 24'hFFFFFF; pl = 24'd4095; pt = 24'd0;
        end
        default: begin
          pick = $urandom_range(0, 9);
          thr = (pick == 0) ? 24'd0 : (pick == 1) ? 24'd4096 :
                (pick == 2) ? 24'($urandom_range(4097, 8191)) : 24'($urandom_range(0, 4096));
          pick = $urandom_range(0, 9);
          cnt = (pick == 0) ? 24'd0 : (pick == 1) ? 24'($urandom_range(129, 255)) :
                (pick == 2) ? 24'd128 : (pick == 3) ? 24'($urandom_range(9, 127)) :
                24'($urandom_range(1, 8));
          pick = $urandom_range(0, 9);
          sx = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
               (pick == 2) ? 24'($urandom) : 24'($urandom_range(16384, 262144));
          pick = $urandom_range(0, 9);
          sy = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
               (pick == 2) ? 24'($urandom) : 24'($urandom_range(16384, 262144));
          pick = $urandom_range(0, 9);
          pl = (pick == 0) ? 24'd0 : (pick == 1) ? 24'd4095 :
               (pick == 2) ? 24'($urandom_range(0, 4095)) : 24'($urandom_range(0, 160));
          pick = $urandom_range(0, 9);
          pt = (pick == 0) ? 24'd0 : (pick == 1) ? 24'd4095 :
               (pick == 2) ? 24'($urandom_range(0, 4095)) : 24'($urandom_range(0, 160));
        end
      endcase
      drain_and_settle();
      program_config(thr, cnt, sx, sy, pl, pt);

      rows = (n_eff > 16) ? 2 : $urandom_range(6, 14);
      repeat (rows) begin
        full = HEAD_LEN + n_eff;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          len = $urandom_range(1, full - 1);
        end else if (pick == 1 && long_rows < 3) begin
          // long enough to push the element counter into saturation
          len = full + 260;
          long_rows++;
        end else if (pick < 6) begin
          len = full + $urandom_range(1, 4);
        end else begin
          len = full;
        end
        row_buf.delete();
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 7);
          if (i < 4) begin
            add_element((pick == 0) ? 24'($urandom) : (pick == 1) ? 24'd0 :
                        24'($urandom_range(0, 700 * 4096)));
          end else if (i == 4) begin
            add_element((pick == 0) ? 24'($urandom) : (pick == 1) ? 24'd0 :
                        (pick == 2) ? 24'd4096 : 24'($urandom_range(0, 4096)));
          end else if (i < full) begin
            // coarse scores often tie, to exercise first-maximum selection
            add_element((pick == 0) ? 24'($urandom) :
                        (pick < 3) ? 24'($urandom_range(0, 2) * 2048) :
                        24'($urandom_range(0, 4096)));
          end else begin
            add_element(24'($urandom));
          end
        end
        send_row();
      end
    end
    drain_and_settle();

    $display("Sent %0d rows, %0d items (%0d box, objectness or score) over %0d register settings.",
             rows_sent, total_items, useful_items, settings_used);
    $display("Compared %0d detections field by field, %0d mismatches, %0d outstanding.",
             detections_checked, mismatch_count, detections_due);
    if (mismatch_count == 0 && detections_due == 0) begin
      $display("PASS detection_row_decode_top");
    end else begin
      $display("FAIL detection_row_decode_top");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/drd_pkg.sv
design/detection_row_decode_top.sv
dv/drd_decode_checker.sv
dv/tb_detection_row_decode_top.sv
